@@ design/pidaw_pkg.sv @@
// Shared types, constants and control encodings of the PID regulator with anti-windup.
package pidaw_pkg;

	localparam int ERR_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int FRAC_W    = 8;
	localparam int ACC_W     = 48;
	localparam int PROD_W    = ACC_W + GAIN_W;
	localparam int PROP_W    = 32;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [PROP_W-1:0] prop_t;
	typedef logic signed [OUT_W-1:0]  drive_t;

	localparam acc_t ACC_MAX = acc_t'({1'b0, {(ACC_W-1){1'b1}}});
	localparam acc_t ACC_MIN = acc_t'({1'b1, {(ACC_W-1){1'b0}}});

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_INTEG,
		REG_GAIN_DERIV,
		REG_GAIN_WINDUP,
		REG_LIMIT_HIGH,
		REG_LIMIT_LOW
	} reg_idx_t;

	typedef struct packed {
		gain_t kp;
		gain_t ki;
		gain_t kd;
		gain_t kc;
		gain_t lim_hi;
		gain_t lim_lo;
	} gains_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_ACC_I,
		ST_ACC_W,
		ST_SUM_I,
		ST_SUM_D,
		ST_CLAMP
	} state_t;

	typedef enum logic [1:0] {
		MA_ERR,
		MA_SDIFF,
		MA_DIFF
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_KP,
		MB_KI,
		MB_KC,
		MB_KD
	} mul_b_t;

	typedef enum logic [2:0] {
		AA_PROD,
		AA_INTEG,
		AA_UP,
		AA_PRE,
		AA_RES
	} add_a_t;

	typedef enum logic [1:0] {
		AB_PREV,
		AB_PROD,
		AB_INTEG,
		AB_PRE
	} add_b_t;

	typedef struct packed {
		logic   load_err;
		logic   clear;
		logic   mul_en;
		mul_a_t mul_a;
		mul_b_t mul_b;
		logic   frac_shift;
		add_a_t add_a;
		add_b_t add_b;
		logic   add_sub;
		logic   wr_up;
		logic   wr_diff;
		logic   wr_integ;
		logic   zero_integ;
		logic   wr_pre;
		logic   finish;
	} cmd_t;

endpackage

@@ design/pidaw_if.sv @@
// Handshake channels of the PID regulator: input word, result word, register write.
interface pidaw_in_if import pidaw_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	err_t error_in;

	modport source(output valid, output func, output error_in, input ready);
	modport sink(input valid, input func, input error_in, output ready);
endinterface

interface pidaw_out_if import pidaw_pkg::*; ();
	logic   valid;
	logic   ready;
	drive_t drive;
	logic   at_limit;

	modport source(output valid, output drive, output at_limit, input ready);
	modport sink(input valid, input drive, input at_limit, output ready);
endinterface

interface pidaw_cfg_if import pidaw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	gain_t                data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ design/pidaw_cfg_regs.sv @@
// Gain and limit register file written through the configuration channel.
module pidaw_cfg_regs import pidaw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pidaw_cfg_if.sink   cfg,
	output gains_t      gains
);

	gains_t gains_q;

	assign cfg.ready = 1'b1;
	assign gains     = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_GAIN_PROP:   gains_q.kp     <= cfg.data;
				REG_GAIN_INTEG:  gains_q.ki     <= cfg.data;
				REG_GAIN_DERIV:  gains_q.kd     <= cfg.data;
				REG_GAIN_WINDUP: gains_q.kc     <= cfg.data;
				REG_LIMIT_HIGH:  gains_q.lim_hi <= cfg.data;
				REG_LIMIT_LOW:   gains_q.lim_lo <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/pidaw_datapath.sv @@
// Shared multiplier, saturating adder, clamp and controller state registers.
module pidaw_datapath import pidaw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  gains_t gains,
	input  err_t   err_in,
	output drive_t drive,
	output logic   at_limit
);

	localparam int HI_EXT_W = ACC_W - GAIN_W - FRAC_W;

	err_t   err_q;
	prod_t  prod_q;
	prop_t  up_q;
	prop_t  prev_q;
	acc_t   diff_q;
	acc_t   integ_q;
	acc_t   sdiff_q;
	acc_t   pre_q;
	drive_t drive_q;
	logic   lim_q;

	acc_t                 mul_a;
	gain_t                mul_b;
	prod_t                prod;
	prod_t                sh;
	logic [PROD_W-ACC_W:0] sh_top;
	acc_t                 prod_sat;
	acc_t                 add_a;
	acc_t                 add_b;
	logic [ACC_W:0]       ax;
	logic [ACC_W:0]       bx;
	logic [ACC_W:0]       sum;
	acc_t                 add_sat;
	acc_t                 hq;
	acc_t                 lq;
	logic                 over;
	logic                 under;
	acc_t                 res;

	always_comb begin
		case (cmd.mul_a)
			MA_ERR:   mul_a = acc_t'(err_q);
			MA_SDIFF: mul_a = sdiff_q;
			MA_DIFF:  mul_a = diff_q;
			default:  mul_a = diff_q;
		endcase
		case (cmd.mul_b)
			MB_KP:   mul_b = gains.kp;
			MB_KI:   mul_b = gains.ki;
			MB_KC:   mul_b = gains.kc;
			MB_KD:   mul_b = gains.kd;
			default: mul_b = gains.kd;
		endcase
	end

	assign prod = prod_t'(mul_a) * prod_t'(mul_b);

	// drop fraction toward minus infinity, then saturate
	assign sh     = cmd.frac_shift ? (prod_q >>> FRAC_W) : prod_q;
	assign sh_top = sh[PROD_W-1:ACC_W-1];
	assign prod_sat = ((&sh_top) || !(|sh_top)) ? sh[ACC_W-1:0]
		: (sh[PROD_W-1] ? ACC_MIN : ACC_MAX);

	assign hq    = acc_t'({{HI_EXT_W{gains.lim_hi[GAIN_W-1]}}, gains.lim_hi, {FRAC_W{1'b0}}});
	assign lq    = acc_t'({{HI_EXT_W{gains.lim_lo[GAIN_W-1]}}, gains.lim_lo, {FRAC_W{1'b0}}});
	assign over  = pre_q > hq;
	assign under = pre_q < lq;
	assign res   = over ? hq : (under ? lq : pre_q);

	always_comb begin
		case (cmd.add_a)
			AA_PROD:  add_a = prod_sat;
			AA_INTEG: add_a = integ_q;
			AA_UP:    add_a = acc_t'(up_q);
			AA_PRE:   add_a = pre_q;
			AA_RES:   add_a = res;
			default:  add_a = res;
		endcase
		case (cmd.add_b)
			AB_PREV:  add_b = acc_t'(prev_q);
			AB_PROD:  add_b = prod_sat;
			AB_INTEG: add_b = integ_q;
			AB_PRE:   add_b = pre_q;
			default:  add_b = pre_q;
		endcase
	end

	assign ax  = {add_a[ACC_W-1], add_a};
	assign bx  = {add_b[ACC_W-1], add_b};
	assign sum = cmd.add_sub ? (ax - bx) : (ax + bx);
	assign add_sat = (sum[ACC_W] == sum[ACC_W-1]) ? acc_t'(sum[ACC_W-1:0])
		: (sum[ACC_W] ? ACC_MIN : ACC_MAX);

	always_ff @(posedge clk) begin
		if (cmd.load_err)
			err_q <= err_in;
		if (cmd.mul_en)
			prod_q <= prod;
		if (cmd.wr_up)
			up_q <= prod_sat[PROP_W-1:0];
		if (cmd.wr_diff)
			diff_q <= add_sat;
		if (cmd.wr_pre)
			pre_q <= add_sat;
		if (cmd.finish) begin
			drive_q <= res[FRAC_W+OUT_W-1:FRAC_W];
			lim_q   <= over || under;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			sdiff_q <= '0;
			prev_q  <= '0;
		end else begin
			if (cmd.clear) begin
				integ_q <= '0;
				sdiff_q <= '0;
			end
			if (cmd.wr_integ)
				integ_q <= (cmd.zero_integ && gains.ki == '0) ? '0 : add_sat;
			if (cmd.finish) begin
				sdiff_q <= add_sat;
				prev_q  <= up_q;
			end
		end
	end

	assign drive    = drive_q;
	assign at_limit = lim_q;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (integ_q == '0 && sdiff_q == '0))
		else $error("clear left integral or saturation difference nonzero");

	a_ki_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_integ && cmd.zero_integ && gains.ki == '0) |=> integ_q == '0)
		else $error("integral not forced to zero with zero integral gain");

	a_limit_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (over || under)) |=>
			(drive_q == $past(gains.lim_hi) || drive_q == $past(gains.lim_lo)))
		else $error("clamped drive differs from both limits");

endmodule

@@ design/pidaw_ctrl.sv @@
// Step sequencer driving the shared datapath and the result handshake.
module pidaw_ctrl import pidaw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   done;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign done      = (state_q == ST_CLAMP) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && !in_func) state_d = ST_MUL_P;
			ST_MUL_P: state_d = ST_MUL_I;
			ST_MUL_I: state_d = ST_ACC_I;
			ST_ACC_I: state_d = ST_ACC_W;
			ST_ACC_W: state_d = ST_SUM_I;
			ST_SUM_I: state_d = ST_SUM_D;
			ST_SUM_D: state_d = ST_CLAMP;
			ST_CLAMP: if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_err = accept;
				cmd.clear    = accept && in_func;
			end
			ST_MUL_P: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = MA_ERR;
				cmd.mul_b  = MB_KP;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_a   = MA_ERR;
				cmd.mul_b   = MB_KI;
				cmd.wr_up   = 1'b1;
				cmd.add_a   = AA_PROD;
				cmd.add_b   = AB_PREV;
				cmd.add_sub = 1'b1;
				cmd.wr_diff = 1'b1;
			end
			ST_ACC_I: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_a    = MA_SDIFF;
				cmd.mul_b    = MB_KC;
				cmd.add_a    = AA_INTEG;
				cmd.add_b    = AB_PROD;
				cmd.wr_integ = 1'b1;
			end
			ST_ACC_W: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_a      = MA_DIFF;
				cmd.mul_b      = MB_KD;
				cmd.frac_shift = 1'b1;
				cmd.add_a      = AA_INTEG;
				cmd.add_b      = AB_PROD;
				cmd.wr_integ   = 1'b1;
				cmd.zero_integ = 1'b1;
			end
			ST_SUM_I: begin
				cmd.add_a  = AA_UP;
				cmd.add_b  = AB_INTEG;
				cmd.wr_pre = 1'b1;
			end
			ST_SUM_D: begin
				cmd.frac_shift = 1'b1;
				cmd.add_a      = AA_PRE;
				cmd.add_b      = AB_PROD;
				cmd.wr_pre     = 1'b1;
			end
			ST_CLAMP: begin
				cmd.add_a   = AA_RES;
				cmd.add_b   = AB_PRE;
				cmd.add_sub = 1'b1;
				cmd.finish  = done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_step_length: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_func) |-> ##7 (state_q == ST_CLAMP))
		else $error("compute step did not reach clamp after seven cycles");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("finished step did not raise result valid");

	a_clamp_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLAMP && out_valid_q && !out_ready) |=> (state_q == ST_CLAMP))
		else $error("clamp step overwrote an untaken result");

endmodule

@@ design/pid_regulator_antiwindup_core.sv @@
// PID regulator with back-calculation anti-windup: top level.
// A compute word is accepted in idle; its result becomes valid after the clamp step finishes.
// A new compute word waits until the previous one is finished, as the shared multiplier and
// saturating adder step through P, I, windup and D terms; a clear word is handled in idle.
// A finished result stalls the clamp step only while the previous result is untaken.
// Reset clears gains, limits, integral, saturation difference and previous proportional.
module pid_regulator_antiwindup_core import pidaw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pidaw_in_if.sink     in_ch,
	pidaw_out_if.source  out_ch,
	pidaw_cfg_if.sink    cfg
);

	gains_t gains;
	cmd_t   cmd;

	pidaw_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.gains  (gains)
	);

	pidaw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	pidaw_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.gains    (gains),
		.err_in   (in_ch.error_in),
		.drive    (out_ch.drive),
		.at_limit (out_ch.at_limit)
	);

endmodule
